FILE: hdl/sbpd_pkg.sv
// ----------------------------------------------------------------------------
// sbpd_pkg
// Shared widths, reset values, register codes and types of the spectral band
// peak detector.
// ----------------------------------------------------------------------------
`default_nettype none

package sbpd_pkg;

    localparam int FRAME_BINS = 1024;
    localparam int COUNT_BITS = 32;

    localparam int IDX_W   = $clog2(FRAME_BINS);
    localparam int PWR_W   = 16;
    localparam int HOUR_W  = 5;
    localparam int OUT_CNT_W = 32;

    localparam int BSTART_W = 10;
    localparam int BLEN_W   = 7;
    localparam int SCAN_W   = 11;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    // wide enough for bin index, band end and scan count without overflow
    localparam int CMP_W = ((IDX_W > SCAN_W) ? IDX_W : SCAN_W) + 1;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(FRAME_BINS - 1);
    localparam logic signed [PWR_W-1:0] PWR_MIN = {1'b1, {(PWR_W-1){1'b0}}};

    localparam logic [BSTART_W-1:0] BAND_START_RST  = BSTART_W'(140);
    localparam logic [BLEN_W-1:0]   BAND_LEN_RST    = BLEN_W'(6);
    localparam logic [SCAN_W-1:0]   SCAN_COUNT_RST  = SCAN_W'(499);
    localparam logic [HOUR_W-1:0]   NIGHT_FROM_RST  = HOUR_W'(23);
    localparam logic [HOUR_W-1:0]   NIGHT_UNTIL_RST = HOUR_W'(11);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BAND_START  = 3'd0,
        CFG_BAND_LEN    = 3'd1,
        CFG_SCAN_COUNT  = 3'd2,
        CFG_NIGHT_FROM  = 3'd3,
        CFG_NIGHT_UNTIL = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [BSTART_W-1:0] band_start;
        logic [BLEN_W-1:0]   band_len;
        logic [SCAN_W-1:0]   scan_count;
        logic [HOUR_W-1:0]   night_from;
        logic [HOUR_W-1:0]   night_until;
    } t_cfg;

    typedef struct packed {
        logic signed [PWR_W-1:0] band_peak;
        logic                    is_peak_event;
    } t_frame_res;

    typedef struct packed {
        logic [COUNT_BITS-1:0] night_total;
        logic [COUNT_BITS-1:0] night_peaks;
        logic [COUNT_BITS-1:0] day_total;
        logic [COUNT_BITS-1:0] day_peaks;
    } t_counts;

    typedef struct packed {
        logic                  go;
        logic                  night;
        logic                  event_hit;
    } t_cnt_upd;

endpackage

`default_nettype wire

FILE: hdl/sbpd_if.sv
// ----------------------------------------------------------------------------
// sbpd_in_if / sbpd_out_if
// Valid/ready channels carrying bin items in and frame results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface sbpd_in_if import sbpd_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [PWR_W-1:0]  bin_power;
    logic [HOUR_W-1:0]        frame_hour;
    logic                     last_bin;

    modport source (output valid, bin_power, frame_hour, last_bin, input ready);
    modport sink   (input valid, bin_power, frame_hour, last_bin, output ready);
endinterface

interface sbpd_out_if import sbpd_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [PWR_W-1:0]  band_peak;
    logic                     is_peak_event;
    logic                     is_night;
    logic [OUT_CNT_W-1:0]     night_total;
    logic [OUT_CNT_W-1:0]     night_peaks;
    logic [OUT_CNT_W-1:0]     day_total;
    logic [OUT_CNT_W-1:0]     day_peaks;

    modport source (output valid, band_peak, is_peak_event, is_night, night_total,
                    night_peaks, day_total, day_peaks, input ready);
    modport sink   (input valid, band_peak, is_peak_event, is_night, night_total,
                    night_peaks, day_total, day_peaks, output ready);
endinterface

`default_nettype wire

FILE: hdl/sbpd_cfg_regs.sv
// ----------------------------------------------------------------------------
// sbpd_cfg_regs
// Configuration register file, write only.
// ----------------------------------------------------------------------------
`default_nettype none

module sbpd_cfg_regs import sbpd_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.band_start  <= BAND_START_RST;
            r_cfg.band_len    <= BAND_LEN_RST;
            r_cfg.scan_count  <= SCAN_COUNT_RST;
            r_cfg.night_from  <= NIGHT_FROM_RST;
            r_cfg.night_until <= NIGHT_UNTIL_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_BAND_START:  r_cfg.band_start  <= i_cfg_data[BSTART_W-1:0];
                CFG_BAND_LEN:    r_cfg.band_len    <= i_cfg_data[BLEN_W-1:0];
                CFG_SCAN_COUNT:  r_cfg.scan_count  <= i_cfg_data[SCAN_W-1:0];
                CFG_NIGHT_FROM:  r_cfg.night_from  <= i_cfg_data[HOUR_W-1:0];
                CFG_NIGHT_UNTIL: r_cfg.night_until <= i_cfg_data[HOUR_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

FILE: hdl/sbpd_band_scan.sv
// ----------------------------------------------------------------------------
// sbpd_band_scan
// Bin index and the band and scan running maxima of the current frame.
// ----------------------------------------------------------------------------
`default_nettype none

module sbpd_band_scan import sbpd_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire t_cfg                    i_cfg,
    input  wire logic                    i_step,
    input  wire logic signed [PWR_W-1:0] i_power,
    input  wire logic                    i_last,
    output t_frame_res                   o_res
);

    logic [IDX_W-1:0]        r_bin_index;
    logic signed [PWR_W-1:0] r_band_max;
    logic signed [PWR_W-1:0] r_scan_max;

    logic [IDX_W-1:0]        n_bin_index;
    logic signed [PWR_W-1:0] n_band_max;
    logic signed [PWR_W-1:0] n_scan_max;

    logic [CMP_W-1:0] idx_x;
    logic [CMP_W-1:0] band_end;
    logic             in_band;
    logic             in_scan;

    always_comb begin
        idx_x    = CMP_W'(r_bin_index);
        band_end = CMP_W'(i_cfg.band_start) + CMP_W'(i_cfg.band_len);
        in_band  = (idx_x >= CMP_W'(i_cfg.band_start)) && (idx_x < band_end);
        in_scan  = idx_x < CMP_W'(i_cfg.scan_count);

        n_band_max  = (in_band && (i_power > r_band_max)) ? i_power : r_band_max;
        n_scan_max  = (in_scan && (i_power > r_scan_max)) ? i_power : r_scan_max;
        n_bin_index = (r_bin_index == IDX_LAST) ? r_bin_index : r_bin_index + 1'b1;

        o_res.band_peak     = n_band_max;
        o_res.is_peak_event = n_band_max >= n_scan_max;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_index <= '0;
            r_band_max  <= PWR_MIN;
            r_scan_max  <= PWR_MIN;
        end else if (i_step) begin
            if (i_last) begin
                r_bin_index <= '0;
                r_band_max  <= PWR_MIN;
                r_scan_max  <= PWR_MIN;
            end else begin
                r_bin_index <= n_bin_index;
                r_band_max  <= n_band_max;
                r_scan_max  <= n_scan_max;
            end
        end
    end

endmodule

`default_nettype wire

FILE: hdl/sbpd_class_count.sv
// ----------------------------------------------------------------------------
// sbpd_class_count
// Saturating night/day frame and peak-event counters.
// ----------------------------------------------------------------------------
`default_nettype none

module sbpd_class_count import sbpd_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_cnt_upd i_upd,
    output t_counts       o_next
);

    t_counts r_cnt;
    t_counts n_cnt;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    always_comb begin
        n_cnt = r_cnt;
        if (i_upd.night) begin
            n_cnt.night_total = sat_inc(r_cnt.night_total);
            if (i_upd.event_hit) begin
                n_cnt.night_peaks = sat_inc(r_cnt.night_peaks);
            end
        end else begin
            n_cnt.day_total = sat_inc(r_cnt.day_total);
            if (i_upd.event_hit) begin
                n_cnt.day_peaks = sat_inc(r_cnt.day_peaks);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_upd.go) begin
            r_cnt <= n_cnt;
        end
    end

    assign o_next = n_cnt;

endmodule

`default_nettype wire

FILE: hdl/spectral_band_peak_detector.sv
// ----------------------------------------------------------------------------
// spectral_band_peak_detector
// Per-frame band peak detection with night/day event statistics.
// ----------------------------------------------------------------------------
// Takes one spectrum bin per cycle. A bin item is registered on accept and
// folded into the band and scan maxima as it leaves that register; the last
// bin of a frame loads the result register, so each result passes through the
// input register and the result register. Sustained rate is one bin per
// clock, set by the single compare/update step of the maxima; the input side
// keeps flowing while a result waits, and stalls only when a last bin meets a
// full result register. Counters saturate and are never cleared except by
// reset. Write configuration only while no frame is in progress.
// ----------------------------------------------------------------------------
`default_nettype none

module spectral_band_peak_detector import sbpd_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    sbpd_in_if.sink                    i_bin,
    sbpd_out_if.source                 o_res
);

    typedef struct packed {
        t_frame_res frame;
        logic       is_night;
        t_counts    counts;
    } t_result;

    t_cfg       cfg;
    t_frame_res frame_res;
    t_counts    cnt_next;
    t_cnt_upd   cnt_upd;

    logic                    r_s1_valid;
    logic signed [PWR_W-1:0] r_s1_power;
    logic [HOUR_W-1:0]       r_s1_hour;
    logic                    r_s1_last;

    logic    r_out_valid;
    t_result r_out;

    logic out_free;
    logic s1_go;
    logic night;

    sbpd_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    assign out_free    = !r_out_valid || o_res.ready;
    assign s1_go       = r_s1_valid && (!r_s1_last || out_free);
    assign i_bin.ready = !r_s1_valid || s1_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_bin.ready) begin
            r_s1_valid <= i_bin.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_bin.ready && i_bin.valid) begin
            r_s1_power <= i_bin.bin_power;
            r_s1_hour  <= i_bin.frame_hour;
            r_s1_last  <= i_bin.last_bin;
        end
    end

    sbpd_band_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_step  (s1_go),
        .i_power (r_s1_power),
        .i_last  (r_s1_last),
        .o_res   (frame_res)
    );

    assign night = (r_s1_hour >= cfg.night_from) || (r_s1_hour < cfg.night_until);

    assign cnt_upd.go        = s1_go && r_s1_last;
    assign cnt_upd.night     = night;
    assign cnt_upd.event_hit = frame_res.is_peak_event;

    sbpd_class_count u_count (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_upd   (cnt_upd),
        .o_next  (cnt_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && r_s1_last) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && r_s1_last) begin
            r_out.frame    <= frame_res;
            r_out.is_night <= night;
            r_out.counts   <= cnt_next;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.band_peak     = r_out.frame.band_peak;
    assign o_res.is_peak_event = r_out.frame.is_peak_event;
    assign o_res.is_night      = r_out.is_night;
    assign o_res.night_total   = OUT_CNT_W'(r_out.counts.night_total);
    assign o_res.night_peaks   = OUT_CNT_W'(r_out.counts.night_peaks);
    assign o_res.day_total     = OUT_CNT_W'(r_out.counts.day_total);
    assign o_res.day_peaks     = OUT_CNT_W'(r_out.counts.day_peaks);

endmodule

`default_nettype wire

FILE: dv/sbpd_frame_check.sv
// ----------------------------------------------------------------------------
// sbpd_frame_check
// Watches the bin and result channels and the register port of the spectral
// band peak detector. It folds every accepted bin into its own band and scan
// maxima and class counters, queues the summary that each frame's last bin
// produces, and compares each accepted result with the oldest queued summary.
// ----------------------------------------------------------------------------
`default_nettype none

module sbpd_frame_check import sbpd_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    sbpd_in_if                         i_bin,
    sbpd_out_if                        i_res,
    output int                         o_fail_count,
    output int                         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [PWR_W-1:0] band_peak;
        logic                    is_peak_event;
        logic                    is_night;
        logic [OUT_CNT_W-1:0]    night_total;
        logic [OUT_CNT_W-1:0]    night_peaks;
        logic [OUT_CNT_W-1:0]    day_total;
        logic [OUT_CNT_W-1:0]    day_peaks;
    } t_frame_sum;

    t_cfg                    regs;
    logic [IDX_W-1:0]        bin_idx;
    logic signed [PWR_W-1:0] band_max;
    logic signed [PWR_W-1:0] scan_max;
    logic [COUNT_BITS-1:0]   night_frames;
    logic [COUNT_BITS-1:0]   night_hits;
    logic [COUNT_BITS-1:0]   day_frames;
    logic [COUNT_BITS-1:0]   day_hits;
    t_frame_sum              frame_q[$];

    function automatic logic [COUNT_BITS-1:0] bump(logic [COUNT_BITS-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    task automatic report_mismatch(string msg);
        $display("%0t ERROR %s", $time, msg);
        o_fail_count++;
    endtask

    task automatic compare_field(string name, logic [31:0] want_v, logic [31:0] got_v);
        if (got_v !== want_v)
            report_mismatch($sformatf("%s: expected %0h, got %0h", name, want_v, got_v));
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (t_cfg_idx'(idx))
            CFG_BAND_START:  regs.band_start  = data[BSTART_W-1:0];
            CFG_BAND_LEN:    regs.band_len    = data[BLEN_W-1:0];
            CFG_SCAN_COUNT:  regs.scan_count  = data[SCAN_W-1:0];
            CFG_NIGHT_FROM:  regs.night_from  = data[HOUR_W-1:0];
            CFG_NIGHT_UNTIL: regs.night_until = data[HOUR_W-1:0];
            default: ;
        endcase
    endtask

    task automatic fold_bin(logic signed [PWR_W-1:0] pwr, logic [HOUR_W-1:0] hour,
                            logic last);
        int unsigned idx;
        int unsigned lo;
        int unsigned hi;
        logic        hit;
        logic        night;
        t_frame_sum  sum;
        idx = bin_idx;
        lo  = regs.band_start;
        hi  = lo + regs.band_len;
        if (idx >= lo && idx < hi && pwr > band_max)
            band_max = pwr;
        if (idx < regs.scan_count && pwr > scan_max)
            scan_max = pwr;
        if (bin_idx != IDX_LAST)
            bin_idx = bin_idx + 1'b1;
        if (last) begin
            hit   = band_max >= scan_max;
            night = (hour >= regs.night_from) || (hour < regs.night_until);
            if (night) begin
                night_frames = bump(night_frames);
                if (hit)
                    night_hits = bump(night_hits);
            end else begin
                day_frames = bump(day_frames);
                if (hit)
                    day_hits = bump(day_hits);
            end
            sum.band_peak     = band_max;
            sum.is_peak_event = hit;
            sum.is_night      = night;
            sum.night_total   = OUT_CNT_W'(night_frames);
            sum.night_peaks   = OUT_CNT_W'(night_hits);
            sum.day_total     = OUT_CNT_W'(day_frames);
            sum.day_peaks     = OUT_CNT_W'(day_hits);
            frame_q.push_back(sum);
            bin_idx  = '0;
            band_max = PWR_MIN;
            scan_max = PWR_MIN;
        end
    endtask

    task automatic check_result();
        t_frame_sum want;
        if (frame_q.size() == 0) begin
            report_mismatch($sformatf("result with no frame pending, band_peak %0h",
                                      i_res.band_peak));
        end else begin
            want = frame_q.pop_front();
            compare_field("band_peak", 32'(want.band_peak), 32'(i_res.band_peak));
            compare_field("is_peak_event", 32'(want.is_peak_event), 32'(i_res.is_peak_event));
            compare_field("is_night", 32'(want.is_night), 32'(i_res.is_night));
            compare_field("night_total", want.night_total, i_res.night_total);
            compare_field("night_peaks", want.night_peaks, i_res.night_peaks);
            compare_field("day_total", want.day_total, i_res.day_total);
            compare_field("day_peaks", want.day_peaks, i_res.day_peaks);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            regs.band_start  = BAND_START_RST;
            regs.band_len    = BAND_LEN_RST;
            regs.scan_count  = SCAN_COUNT_RST;
            regs.night_from  = NIGHT_FROM_RST;
            regs.night_until = NIGHT_UNTIL_RST;
            bin_idx          = '0;
            band_max         = PWR_MIN;
            scan_max         = PWR_MIN;
            night_frames     = '0;
            night_hits       = '0;
            day_frames       = '0;
            day_hits         = '0;
            frame_q.delete();
            o_fail_count     = 0;
        end else begin
            if (i_cfg_we)
                write_reg(i_cfg_idx, i_cfg_data);
            if (i_bin.valid && i_bin.ready)
                fold_bin(i_bin.bin_power, i_bin.frame_hour, i_bin.last_bin);
            if (i_res.valid === 1'b1 && i_res.ready)
                check_result();
        end
        o_pending = frame_q.size();
    end

endmodule

`default_nettype wire

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the spectral band peak detector. Short directed
// frames hit the reset settings, empty band and scan, the last bin counted in
// both maxima, ties, hours past 23 and frames longer than the bin counter.
// Random phases then reprogram the band, scan and night window and stream
// random frames with random gaps and result stalls, one phase holding off
// results long enough to stall the bin input. Checking is done beside the
// block by sbpd_frame_check.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sbpd_pkg::*;

    localparam int RAND_ITEMS   = 750;
    localparam int MIN_RESULTS  = 48;
    localparam int PHASE_ITEMS  = 90;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_LIMIT  = 2000;
    localparam int unsigned TIMEOUT_NS = 4_000_000;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    pending_cnt;

    int          items_sent = 0;
    int          results_seen = 0;
    int unsigned cur_band_start = BAND_START_RST;
    int unsigned cur_band_len = BAND_LEN_RST;
    bit          tx_calm = 1'b0;
    bit          tx_burst = 1'b0;
    int          tx_left = 0;
    bit          long_hold_req = 1'b0;

    sbpd_in_if  bin_ch ();
    sbpd_out_if res_ch ();

    spectral_band_peak_detector dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_bin      (bin_ch),
        .o_res      (res_ch)
    );

    sbpd_frame_check frame_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_bin        (bin_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_cnt)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic signed [PWR_W-1:0] pick_power(int unsigned mode, bit in_band);
        logic signed [PWR_W-1:0] v;
        v = PWR_W'($urandom);
        case (mode)
            1: v = PWR_W'(int'($urandom_range(0, 6)) - 3);
            2: if (in_band) v = 16'sh7FFF - PWR_W'($urandom_range(0, 2));
            default: ;
        endcase
        if ($urandom_range(0, 31) == 0)
            v = $urandom_range(0, 1) ? PWR_MIN : 16'sh7FFF;
        return v;
    endfunction

    task automatic send_bin(logic signed [PWR_W-1:0] pwr, logic [HOUR_W-1:0] hour,
                            logic last);
        int gap;
        if (tx_left == 0) begin
            tx_calm = ($urandom_range(0, 2) == 0);
            tx_left = 40;
        end
        tx_left--;
        gap = (tx_calm || tx_burst) ? 0 : $urandom_range(0, 5);
        repeat (gap) begin
            @(negedge clk);
            bin_ch.valid     <= 1'b0;
            bin_ch.bin_power <= PWR_W'($urandom);
            bin_ch.last_bin  <= 1'($urandom);
        end
        @(negedge clk);
        bin_ch.valid      <= 1'b1;
        bin_ch.bin_power  <= pwr;
        bin_ch.frame_hour <= hour;
        bin_ch.last_bin   <= last;
        do @(posedge clk); while (!bin_ch.ready);
        items_sent++;
    endtask

    task automatic send_frame(int nbins, int unsigned mode);
        bit          in_band;
        logic [HOUR_W-1:0] hour;
        hour = ($urandom_range(0, 7) == 0) ? HOUR_W'($urandom_range(24, 31))
                                          : HOUR_W'($urandom_range(0, 23));
        for (int k = 0; k < nbins; k++) begin
            in_band = (k >= cur_band_start) && (k < cur_band_start + cur_band_len);
            send_bin(pick_power(mode, in_band),
                     (k == nbins - 1) ? hour : HOUR_W'($urandom), k == nbins - 1);
        end
    endtask

    task automatic write_reg(t_cfg_idx idx, int unsigned val);
        if (idx == CFG_BAND_START)
            cur_band_start = val;
        if (idx == CFG_BAND_LEN)
            cur_band_len = val;
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= CFG_DATA_W'(val);
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    // stop offering bins and let every frame result come out
    task automatic drain();
        int waited;
        @(negedge clk);
        bin_ch.valid <= 1'b0;
        waited = 0;
        while (pending_cnt != 0 && waited < DRAIN_LIMIT) begin
            @(negedge clk);
            waited++;
        end
        repeat (4) @(negedge clk);
    endtask

    initial begin : result_sink
        int stall;
        int rx_left;
        bit rx_calm;
        rx_left = 0;
        rx_calm = 1'b0;
        res_ch.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                repeat (LONG_HOLD) @(negedge clk) res_ch.ready <= 1'b0;
            end
            if (rx_left == 0) begin
                rx_calm = ($urandom_range(0, 2) == 0);
                rx_left = 30;
            end
            stall = rx_calm ? 0 : $urandom_range(0, 5);
            repeat (stall) @(negedge clk) res_ch.ready <= 1'b0;
            @(negedge clk) res_ch.ready <= 1'b1;
            do @(posedge clk); while (!(res_ch.valid === 1'b1 && res_ch.ready));
            results_seen++;
            rx_left--;
        end
    end

    initial begin : stimulus
        int          phase;
        int          base;
        int          phase_start;
        int unsigned r;
        int unsigned mode;
        bin_ch.valid      = 1'b0;
        bin_ch.bin_power  = '0;
        bin_ch.frame_hour = '0;
        bin_ch.last_bin   = 1'b0;
        cfg_we   = 1'b0;
        cfg_idx  = CFG_BAND_START;
        cfg_data = '0;
        rst_n    = 1'b0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: band at 140 is never reached by short frames
        send_bin(PWR_MIN, 5'd23, 1'b1);
        send_bin(16'sh7FFF, 5'd4, 1'b0);
        send_bin(-16'sd1, 5'd11, 1'b1);
        drain();

        write_reg(CFG_BAND_START, 0);
        write_reg(CFG_BAND_LEN, 1);
        write_reg(CFG_SCAN_COUNT, 1);
        write_reg(CFG_NIGHT_FROM, 0);
        write_reg(CFG_NIGHT_UNTIL, 0);
        send_bin(16'sd5, 5'd0, 1'b0);
        send_bin(16'sd100, 5'd0, 1'b0);
        send_bin(PWR_MIN, 5'd31, 1'b1);
        drain();

        // empty band and empty scan
        write_reg(CFG_BAND_LEN, 0);
        write_reg(CFG_SCAN_COUNT, 0);
        send_bin(16'sd77, 5'd2, 1'b0);
        send_bin(-16'sd9, 5'd16, 1'b1);
        drain();

        write_reg(CFG_BAND_START, 2);
        write_reg(CFG_BAND_LEN, 3);
        write_reg(CFG_SCAN_COUNT, 5);
        write_reg(CFG_NIGHT_FROM, 23);
        write_reg(CFG_NIGHT_UNTIL, 0);
        // last bin carries the peak of both maxima
        send_bin(16'sd0, 5'd0, 1'b0);
        send_bin(16'sd0, 5'd0, 1'b0);
        send_bin(16'sd0, 5'd0, 1'b0);
        send_bin(16'sd10, 5'd0, 1'b0);
        send_bin(16'sd20, 5'd24, 1'b1);
        send_bin(16'sd10, 5'd0, 1'b0);
        send_bin(16'sd0, 5'd0, 1'b0);
        send_bin(16'sd9, 5'd0, 1'b0);
        send_bin(16'sd9, 5'd0, 1'b0);
        send_bin(16'sd9, 5'd22, 1'b1);
        // tie between band and scan
        send_bin(16'sd7, 5'd0, 1'b0);
        send_bin(16'sd7, 5'd0, 1'b0);
        send_bin(16'sd7, 5'd8, 1'b1);
        drain();

        // band running past the top bin, frame longer than the bin counter
        write_reg(CFG_BAND_START, 1000);
        write_reg(CFG_BAND_LEN, 64);
        write_reg(CFG_SCAN_COUNT, 1024);
        write_reg(CFG_NIGHT_UNTIL, 23);
        for (int k = 0; k < 1029; k++)
            send_bin(pick_power(0, 1'b0), HOUR_W'($urandom), 1'b0);
        send_bin(16'sh7FFF, 5'd3, 1'b1);
        drain();
        write_reg(CFG_BAND_START, 1023);
        write_reg(CFG_BAND_LEN, 1);
        write_reg(CFG_NIGHT_FROM, 0);
        send_frame(1025, 0);
        drain();

        base  = items_sent;
        phase = 0;
        while (items_sent - base < RAND_ITEMS || results_seen < MIN_RESULTS) begin
            drain();
            r = $urandom_range(0, 9);
            write_reg(CFG_BAND_START, (r == 0) ? 0 : (r == 1) ? 1023 : $urandom_range(0, 30));
            r = $urandom_range(0, 9);
            write_reg(CFG_BAND_LEN, (r == 0) ? 64 : (r == 1) ? 1 : $urandom_range(1, 64));
            r = $urandom_range(0, 9);
            write_reg(CFG_SCAN_COUNT, (r == 0) ? 1024 : (r == 1) ? 1 : $urandom_range(1, 40));
            write_reg(CFG_NIGHT_FROM, $urandom_range(0, 23));
            write_reg(CFG_NIGHT_UNTIL, $urandom_range(0, 23));
            if (phase == 2) begin
                // results held off while short frames keep coming
                long_hold_req = 1'b1;
                tx_burst      = 1'b1;
                repeat (24) send_frame($urandom_range(1, 2), $urandom_range(0, 2));
                tx_burst      = 1'b0;
            end
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) begin
                mode = $urandom_range(0, 2);
                send_frame(($urandom_range(0, 4) == 0) ? $urandom_range(1, 3)
                                                      : $urandom_range(4, 40), mode);
            end
            phase++;
        end
        drain();

        if (fail_count == 0 && pending_cnt == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: sim.f
hdl/sbpd_pkg.sv
hdl/sbpd_if.sv
hdl/sbpd_cfg_regs.sv
hdl/sbpd_band_scan.sv
hdl/sbpd_class_count.sv
hdl/spectral_band_peak_detector.sv
dv/sbpd_frame_check.sv
dv/tb.sv
